// ===== rtl/fcca_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcca_pkg
// Shared constants, operation and status codes, and the controller/datapath
// command and status structures of the cluster chain allocator.
// ----------------------------------------------------------------------------
package fcca_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;

    localparam int ENTRY_W = 12;
    localparam int SCAN_W  = ENTRY_W + 1;

    localparam logic [ENTRY_W-1:0] HIGHEST_RST  = 12'd2848;
    localparam logic [ENTRY_W-1:0] END_MARK     = 12'hFFF;
    localparam logic [ENTRY_W-1:0] END_LOW      = 12'hFF8;
    localparam logic [ENTRY_W-1:0] CLUSTER_FREE = 12'h000;
    localparam logic [ENTRY_W-1:0] FIRST_DATA   = 12'd2;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_FIND  = 2'd2;
    localparam logic [1:0] OP_CHAIN = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic clr;
        logic capture;
        logic decode;
        logic look;
        logic scan_init;
        logic scan_two;
        logic scan_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] op;
        logic       range_err;
        logic       last;
        logic       cur_zero;
        logic       cur_end;
        logic       scan_end;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/fat12_cluster_chain_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fat12_cluster_chain_allocator
// FAT12 allocation table with entry write/read, first-free search and
// chain stepping; one result transaction per input transaction.
// ----------------------------------------------------------------------------
// Reset is synchronous; afterwards the table is cleared one entry per cycle,
// before the first input transaction is taken. One transaction is in work at
// a time. Write, range error and last-sector step go from decode straight to
// the result; read and plain chain step look up the entry first; a free search,
// and a chain from a free or end entry, scan the table from index 2. While a
// result waits, the next transaction is taken but not finished.
module fat12_cluster_chain_allocator
    import fcca_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // cluster_index[11:0], entry_value[23:12]
    input  wire logic [1:0]  s_axis_tuser,  // op[1:0]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // result_value[11:0], zero pad[15:12]
    output logic [1:0]       m_axis_tuser,  // status[1:0]
    input  wire logic        i_cfg_wr_en,
    input  wire logic [11:0] i_cfg_wr_data
);

    t_cmd               w_cmd;
    t_sts               w_sts;
    logic [ENTRY_W-1:0] w_out_res;

    fcca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    fcca_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_op          (s_axis_tuser),
        .i_idx         (s_axis_tdata[11:0]),
        .i_val         (s_axis_tdata[23:12]),
        .i_last        (s_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_res     (w_out_res),
        .o_out_st      (m_axis_tuser)
    );

    assign m_axis_tdata = {4'd0, w_out_res};

endmodule
`default_nettype wire

// ===== rtl/fcca_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcca_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module fcca_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/fcca_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcca_ctrl
// Controller state machine: table clearing, transaction intake, entry lookup,
// free search and result hand-off.
// ----------------------------------------------------------------------------
module fcca_ctrl
    import fcca_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_LOOK   = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_sts.op == OP_FIND) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else if (i_sts.range_err || (i_sts.op == OP_WRITE) ||
                             ((i_sts.op == OP_CHAIN) && i_sts.last)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                if ((i_sts.op == OP_CHAIN) && (i_sts.cur_zero || i_sts.cur_end)) begin
                    o_cmd.scan_init = 1'b1;
                    o_cmd.scan_two  = i_sts.cur_zero;
                    n_state         = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/fcca_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcca_dp
// Datapath: allocation table memory, transaction registers, pipelined free
// search, configuration register and the output register.
// ----------------------------------------------------------------------------
module fcca_dp
    import fcca_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic [1:0]         i_op,
    input  wire logic [ENTRY_W-1:0] i_idx,
    input  wire logic [ENTRY_W-1:0] i_val,
    input  wire logic               i_last,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [ENTRY_W-1:0] i_cfg_wr_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [ENTRY_W-1:0]      o_out_res,
    output logic [1:0]              o_out_st
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [ENTRY_W-1:0] TOP_INDEX = ENTRY_W'(TABLE_ENTRIES - 1);

    logic [ENTRY_W-1:0] r_highest;
    logic [AW-1:0]      r_clr;
    logic [1:0]         r_op;
    logic [ENTRY_W-1:0] r_idx;
    logic [ENTRY_W-1:0] r_val;
    logic               r_last;
    logic [ENTRY_W-1:0] r_res;
    logic [1:0]         r_st;
    logic               r_wr;
    logic [SCAN_W-1:0]  r_scan;
    logic [SCAN_W-1:0]  r_chk;
    logic               r_chk_vld;
    logic               r_two;
    logic [ENTRY_W-1:0] r_limit;
    logic               r_out_valid;
    logic [ENTRY_W-1:0] r_out_res;
    logic [1:0]         r_out_st;

    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [ENTRY_W-1:0] w_wr_data;
    logic [AW-1:0]      w_rd_addr;
    logic [ENTRY_W-1:0] w_rd_data;
    logic               w_range;
    logic               w_past;
    logic               w_hit;
    logic               w_cur_zero;
    logic               w_cur_end;

    assign w_range    = {1'b0, r_idx} >= SCAN_W'(TABLE_ENTRIES);
    assign w_past     = r_chk > {1'b0, r_limit};
    assign w_hit      = r_chk_vld && !w_past && (w_rd_data == CLUSTER_FREE);
    assign w_cur_zero = (w_rd_data == CLUSTER_FREE);
    assign w_cur_end  = (w_rd_data >= END_LOW);

    assign w_wr_en   = i_cmd.clr || (i_cmd.finish && r_wr);
    assign w_wr_addr = i_cmd.clr ? r_clr : r_idx[AW-1:0];
    assign w_wr_data = i_cmd.clr ? CLUSTER_FREE : r_res;
    assign w_rd_addr = i_cmd.scan_step ? r_scan[AW-1:0] : r_idx[AW-1:0];

    fcca_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        o_sts           = '0;
        o_sts.clr_last  = (r_clr == AW'(TABLE_ENTRIES - 1));
        o_sts.op        = r_op;
        o_sts.range_err = w_range;
        o_sts.last      = r_last;
        o_sts.cur_zero  = w_cur_zero;
        o_sts.cur_end   = w_cur_end;
        o_sts.scan_end  = r_chk_vld && (w_past || (w_hit && !r_two));
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highest   <= HIGHEST_RST;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_chk_vld   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_highest <= i_cfg_wr_data;
            end
            if (i_cmd.clr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.scan_init) begin
                r_chk_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_chk_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_idx  <= i_idx;
            r_val  <= i_val;
            r_last <= i_last;
            r_res  <= '0;
            r_st   <= ST_OK;
            r_wr   <= 1'b0;
        end
        if (i_cmd.decode && (r_op != OP_FIND)) begin
            if (w_range) begin
                r_st <= ST_RANGE;
            end else if (r_op == OP_WRITE) begin
                r_res <= r_val;
                r_wr  <= 1'b1;
            end else if ((r_op == OP_CHAIN) && r_last) begin
                r_res <= END_MARK;
                r_wr  <= 1'b1;
            end
        end
        if (i_cmd.look) begin
            if (r_op == OP_READ) begin
                r_res <= w_rd_data;
            end else if (!w_cur_zero && !w_cur_end) begin
                r_res <= w_rd_data;
                r_wr  <= 1'b1;
            end
        end
        if (i_cmd.scan_init) begin
            r_scan  <= {1'b0, FIRST_DATA};
            r_two   <= i_cmd.scan_two;
            r_limit <= (r_highest > TOP_INDEX) ? TOP_INDEX : r_highest;
        end
        if (i_cmd.scan_step) begin
            r_scan <= r_scan + SCAN_W'(1);
            r_chk  <= r_scan;
            if (r_chk_vld) begin
                if (w_past) begin
                    r_res <= '0;
                    r_st  <= ST_NOSPACE;
                    r_wr  <= 1'b0;
                end else if (w_hit) begin
                    if (r_two) begin
                        r_two <= 1'b0;
                    end else begin
                        r_res <= r_chk[ENTRY_W-1:0];
                        r_wr  <= (r_op == OP_CHAIN);
                    end
                end
            end
        end
        if (i_cmd.finish) begin
            r_out_res <= r_res;
            r_out_st  <= r_st;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;
    assign o_out_st    = r_out_st;

endmodule
`default_nettype wire

// ===== tb/fcca_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fcca_checker
// Watches the request, result and configuration channels of the cluster chain
// allocator. Every accepted request is run through a local copy of the
// allocation table and the search bound, the predicted result is queued, and
// each result transaction is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module fcca_checker
    import fcca_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // cluster_index[11:0], entry_value[23:12]
    input  wire logic [1:0]  s_axis_tuser,  // op[1:0]
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,  // result_value[11:0], zero pad[15:12]
    input  wire logic [1:0]  m_axis_tuser,  // status[1:0]
    input  wire logic        i_cfg_wr_en,
    input  wire logic [11:0] i_cfg_wr_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output int               o_nospace
);

    typedef struct packed {
        logic [ENTRY_W-1:0] value;
        logic [1:0]         status;
    } t_reply;

    logic [ENTRY_W-1:0] alloc_map [TABLE_ENTRIES];
    logic [ENTRY_W-1:0] search_bound;
    t_reply             reply_q [$];
    int                 mismatches;
    int                 checked;
    int                 nospace;

    function automatic bit search_free(input int start, output int found);
        int limit;
        int i;
        limit = (int'(search_bound) > TABLE_ENTRIES - 1) ? TABLE_ENTRIES - 1
                                                         : int'(search_bound);
        if (start < 2) begin
            start = 2;
        end
        found = 0;
        for (i = start; i <= limit; i++) begin
            if (alloc_map[i] == CLUSTER_FREE) begin
                found = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_reply serve_request(input logic [1:0] op,
                                             input logic [ENTRY_W-1:0] idx,
                                             input logic [ENTRY_W-1:0] val,
                                             input logic last);
        t_reply r;
        int     first_free;
        int     next_cl;
        bit     found;
        r.value  = CLUSTER_FREE;
        r.status = ST_OK;
        if (op == OP_FIND) begin
            if (search_free(2, first_free)) begin
                r.value = first_free[ENTRY_W-1:0];
            end else begin
                r.status = ST_NOSPACE;
            end
        end else if (int'(idx) >= TABLE_ENTRIES) begin
            r.status = ST_RANGE;
        end else if (op == OP_WRITE) begin
            alloc_map[idx] = val;
            r.value = val;
        end else if (op == OP_READ) begin
            r.value = alloc_map[idx];
        end else if (last) begin
            alloc_map[idx] = END_MARK;
            r.value = END_MARK;
        end else begin
            next_cl = int'(alloc_map[idx]);
            found = 1'b1;
            if (alloc_map[idx] == CLUSTER_FREE) begin
                // The current cluster is free too, so it may be the first hit.
                found = search_free(2, first_free) && search_free(first_free + 1, next_cl);
            end else if (alloc_map[idx] >= END_LOW) begin
                found = search_free(2, next_cl);
            end
            if (found) begin
                alloc_map[idx] = next_cl[ENTRY_W-1:0];
                r.value = next_cl[ENTRY_W-1:0];
            end else begin
                r.status = ST_NOSPACE;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply predicted;
        t_reply awaited;
        if (!i_rst_n) begin
            foreach (alloc_map[i]) begin
                alloc_map[i] = CLUSTER_FREE;
            end
            search_bound = HIGHEST_RST;
            reply_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                search_bound = i_cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predicted = serve_request(s_axis_tuser, s_axis_tdata[11:0],
                                          s_axis_tdata[23:12], s_axis_tlast);
                reply_q.push_back(predicted);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                checked++;
                if (m_axis_tuser == ST_NOSPACE) begin
                    nospace++;
                end
                if (reply_q.size() == 0) begin
                    $error("Unexpected result transaction: result_value 0x%03h, status %0d",
                           m_axis_tdata[11:0], m_axis_tuser);
                    mismatches++;
                end else begin
                    awaited = reply_q.pop_front();
                    if (m_axis_tdata[11:0] !== awaited.value) begin
                        $error("result_value mismatch: expected 0x%03h, actual 0x%03h",
                               awaited.value, m_axis_tdata[11:0]);
                        mismatches++;
                    end
                    if (m_axis_tuser !== awaited.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               awaited.status, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= reply_q.size();
        o_checked    <= checked;
        o_nospace    <= nospace;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the cluster chain allocator through directed corner cases and
// random phases under several search bounds, with bursty requests and a
// stalling result receiver. Checking is done by fcca_checker.
// ----------------------------------------------------------------------------
module testbench;
    import fcca_pkg::*;

    localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 32;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_EVERY_THIRD} t_rx_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;  // cluster_index[11:0], entry_value[23:12]
    logic [1:0]  s_axis_tuser  = '0;  // op[1:0]
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // result_value[11:0], zero pad[15:12]
    logic [1:0]  m_axis_tuser;        // status[1:0]
    logic        i_cfg_wr_en   = 1'b0;
    logic [11:0] i_cfg_wr_data = '0;

    int fail_count;
    int pending_count;
    int checked_count;
    int nospace_count;
    int cycle_count  = 0;
    int items_sent   = 0;
    int cfg_writes   = 0;
    int burst_left   = 0;
    bit steady_feed  = 1'b0;
    bit hold_long    = 1'b0;

    fat12_cluster_chain_allocator #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    fcca_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count),
        .o_nospace    (nospace_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_rx_mode mode;
        int       stretch;
        bit       held;
        mode    = RX_OPEN;
        stretch = 0;
        held    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_long && !held) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                held = 1'b1;
            end
            if (stretch == 0) begin
                mode    = t_rx_mode'($urandom_range(0, 3));
                stretch = $urandom_range(10, 60);
            end
            stretch--;
            case (mode)
                RX_OPEN: begin
                    m_axis_tready <= 1'b1;
                end
                RX_COIN: begin
                    m_axis_tready <= ($urandom_range(0, 1) == 1);
                end
                RX_SPARSE: begin
                    m_axis_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_axis_tready <= (stretch % 3 == 0);
                end
            endcase
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [11:0] idx,
                             input logic [11:0] val, input logic last);
        int gap;
        if (burst_left == 0 && !steady_feed) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        s_axis_tuser  <= op;
        s_axis_tdata  <= {val, idx};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    task automatic write_highest(input logic [11:0] bound);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= bound;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    task automatic random_item(input int span);
        logic [1:0]  op;
        logic [11:0] idx;
        logic [11:0] val;
        int          pick;
        pick = $urandom_range(0, 19);
        if (pick < 6) begin
            op = OP_WRITE;
        end else if (pick < 9) begin
            op = OP_READ;
        end else if (pick < 13) begin
            op = OP_FIND;
        end else begin
            op = OP_CHAIN;
        end
        idx  = ($urandom_range(0, 9) < 8) ? 12'($urandom_range(0, span))
                                          : 12'($urandom_range(0, 4095));
        pick = $urandom_range(0, 19);
        if (pick < 6) begin
            val = CLUSTER_FREE;
        end else if (pick < 12) begin
            val = 12'($urandom_range(2, span));
        end else if (pick < 15) begin
            val = 12'($urandom_range(END_LOW, END_MARK));
        end else if (pick < 17) begin
            val = 12'd1;
        end else begin
            val = 12'($urandom_range(0, 4095));
        end
        send_item(op, idx, val, ($urandom_range(0, 9) < 3));
    endtask

    // Links a short file chain into the table and then walks it sector by sector.
    task automatic file_walk(input int span);
        logic [11:0] links [4];
        int          n;
        int          k;
        n = $urandom_range(2, 4);
        for (k = 0; k < n; k++) begin
            links[k] = 12'($urandom_range(2, span));
        end
        for (k = 0; k < n - 1; k++) begin
            send_item(OP_WRITE, links[k], links[k + 1], 1'b0);
        end
        send_item(OP_WRITE, links[n - 1], END_MARK, 1'b0);
        for (k = 0; k < n; k++) begin
            send_item(OP_CHAIN, links[k], 12'($urandom_range(0, 4095)), (k == n - 1));
        end
    endtask

    task automatic run_random(input int count, input int span);
        int start;
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(0, 7) == 0) begin
                file_walk(span);
            end else begin
                random_item(span);
            end
        end
    endtask

    initial begin
        int span;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_WRITE, 12'd0, END_MARK, 1'b0);
        send_item(OP_WRITE, 12'hFFF, 12'hABC, 1'b0);
        send_item(OP_READ, 12'hFFF, 12'd0, 1'b0);
        send_item(OP_READ, 12'd1, 12'd0, 1'b0);
        send_item(OP_FIND, 12'd0, 12'd0, 1'b0);
        send_item(OP_CHAIN, FIRST_DATA, 12'd0, 1'b1);
        send_item(OP_FIND, 12'd0, 12'd0, 1'b1);
        send_item(OP_CHAIN, FIRST_DATA, 12'd0, 1'b0);
        send_item(OP_CHAIN, 12'd3, 12'd0, 1'b0);
        send_item(OP_CHAIN, 12'd5, 12'd0, 1'b0);
        send_item(OP_WRITE, 12'd6, 12'd1, 1'b1);
        send_item(OP_CHAIN, 12'd6, 12'd0, 1'b0);
        send_item(OP_WRITE, 12'd7, 12'hFF7, 1'b0);
        send_item(OP_CHAIN, 12'd7, 12'd0, 1'b0);
        send_item(OP_WRITE, 12'd8, END_LOW, 1'b0);
        send_item(OP_CHAIN, 12'd8, 12'hFFF, 1'b0);
        send_item(OP_WRITE, 12'hAAA, 12'h555, 1'b0);
        send_item(OP_READ, 12'hAAA, 12'd0, 1'b1);
        send_item(OP_WRITE, 12'h555, CLUSTER_FREE, 1'b0);

        write_highest(12'd3);
        send_item(OP_FIND, 12'd0, 12'd0, 1'b0);
        send_item(OP_CHAIN, 12'd10, 12'd0, 1'b0);
        send_item(OP_CHAIN, 12'd10, 12'd0, 1'b1);
        send_item(OP_CHAIN, 12'd0, 12'd0, 1'b0);
        run_random(12, 8);

        write_highest(12'd4095);
        run_random(25, 64);

        span = $urandom_range(10, 60);
        write_highest(span[11:0]);
        run_random(12, span + 4);
        hold_long   = 1'b1;
        steady_feed = 1'b1;
        run_random(10, span + 4);
        steady_feed = 1'b0;
        wait_drained();
        run_random(12, span + 4);

        write_highest(HIGHEST_RST);
        run_random(22, 40);

        span = $urandom_range(3, 4095);
        write_highest(span[11:0]);
        run_random(20, 64);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests and %0d checked results, %0d of them no_space,",
                 items_sent, checked_count, nospace_count);
        $display("over %0d search bound settings including both extremes.", cfg_writes);
        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fcca_pkg.sv
rtl/fcca_ram.sv
rtl/fcca_ctrl.sv
rtl/fcca_dp.sv
rtl/fat12_cluster_chain_allocator.sv
tb/fcca_checker.sv
tb/testbench.sv
